// ===== design/wfdm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wfdm_pkg
// Shared constants, types and the sine table builder for the wow/flutter
// delay modulator.
// ----------------------------------------------------------------------------
package wfdm_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_WIDTH      = 16;

	localparam int TBL_N    = 1 << SINE_TABLE_BITS;
	localparam int ADDR_W   = SINE_TABLE_BITS + 1;
	localparam int ROM_W    = SINE_WIDTH - 1;
	localparam longint SINE_AMP = (longint'(1) << (SINE_WIDTH - 1)) - 1;
	localparam int SUM_FRAC = SINE_WIDTH + 14;
	localparam int ACC_W    = SINE_WIDTH + 18;
	localparam int U_W      = 23;
	localparam int U_LSB    = SUM_FRAC + 1 - 22;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [31:0] ANGLE_RESET = 32'hC000_0000;
	localparam logic [16:0] AMOUNT_ONE  = 17'h1_0000;
	localparam logic [15:0] RAMP_RESET  = 16'd960;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam int DIV_N     = 33;
	localparam int DIV_CNT_W = 6;

	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 33;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [CFG_IDX_W-1:0] REG_WOW_STEP     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_STEP   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLUTTER_STEP = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WOW_GAIN     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_GAIN   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLUTTER_GAIN = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS   = 4'd7;

	localparam logic [1:0] OSC_WOW     = 2'd0;
	localparam logic [1:0] OSC_DRIFT   = 2'd1;
	localparam logic [1:0] OSC_FLUTTER = 2'd2;

	localparam logic [1:0] MUL_SINE  = 2'd0;
	localparam logic [1:0] MUL_DEPTH = 2'd1;
	localparam logic [1:0] MUL_OUT   = 2'd2;

	typedef struct packed {
		logic        [31:0] wow_step;
		logic        [31:0] drift_step;
		logic        [31:0] flutter_step;
		logic signed [15:0] wow_gain;
		logic signed [15:0] drift_gain;
		logic signed [15:0] flutter_gain;
		logic        [23:0] max_depth;
		logic        [15:0] ramp_steps;
	} cfg_t;

	typedef struct packed {
		logic       take;
		logic       goal;
		logic       div_step;
		logic       quo;
		logic       ramp;
		logic       rom_en;
		logic [1:0] rom_sel;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic [1:0] gain_sel;
		logic       acc_clr;
		logic       acc_add;
		logic       clamp;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_busy;
	} sts_t;

	typedef logic [ROM_W-1:0] sine_rom_t [0:TBL_N];

	// Quarter-wave table, Taylor series in Q2.30, scaled and rounded half up.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      s;
		longint      v;
		for (int k = 0; k <= TBL_N; k++) begin
			x = (PI_HALF_Q30 * 64'(k)) / 64'(TBL_N);
			x2 = (x * x) >> 30;
			term = x;
			s = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if ((n & 1) == 1) begin
					s = s - longint'(term);
				end else begin
					s = s + longint'(term);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			if (s > (longint'(1) << 30)) begin
				s = longint'(1) << 30;
			end
			v = (s * SINE_AMP + (longint'(1) << 29)) >>> 30;
			if (v > SINE_AMP) begin
				v = SINE_AMP;
			end
			rom[k] = ROM_W'(v);
		end
		return rom;
	endfunction

endpackage
`default_nettype wire

// ===== design/wow_flutter_delay_modulator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wow_flutter_delay_modulator_core
// Three-oscillator wow/flutter modulator giving a Q16.8 delay offset per
// audio sample.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_stall       amount_target[16:0], restart
//  output    out_valid / out_stall     offset[23:0]
//  config    cfg_we                    cfg_index[3:0], cfg_data[31:0]
//
//  A new item is accepted only once the previous one has been loaded into
//  the output register. A new target with a nonzero ramp length adds a
//  bit-serial divide of the ramp increment (one quotient bit per cycle).
//  One shared 25x33 multiplier forms the three weighted sines and both scales.
//  After reset the block is ready at once; a stalled output holds the
//  sequencer in its last state until the result register empties.
// ----------------------------------------------------------------------------
module wow_flutter_delay_modulator_core import wfdm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [16:0]           amount_target,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [23:0]           offset,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cfg_t'{ramp_steps: RAMP_RESET, default: '0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WOW_STEP:     cfg_q.wow_step     <= cfg_data;
				REG_DRIFT_STEP:   cfg_q.drift_step   <= cfg_data;
				REG_FLUTTER_STEP: cfg_q.flutter_step <= cfg_data;
				REG_WOW_GAIN:     cfg_q.wow_gain     <= cfg_data[15:0];
				REG_DRIFT_GAIN:   cfg_q.drift_gain   <= cfg_data[15:0];
				REG_FLUTTER_GAIN: cfg_q.flutter_gain <= cfg_data[15:0];
				REG_MAX_DEPTH:    cfg_q.max_depth    <= cfg_data[23:0];
				REG_RAMP_STEPS:   cfg_q.ramp_steps   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	wfdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wfdm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.amount_target (amount_target),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.offset        (offset)
	);

endmodule
`default_nettype wire

// ===== design/wfdm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wfdm_ctrl
// Sequencer: steps the datapath through target update, divide, ramp, three
// table reads, the shared multiplier and the output load.
// ----------------------------------------------------------------------------
module wfdm_ctrl import wfdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_GOAL  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_QUO   = 4'd3;
	localparam logic [3:0] ST_RAMP  = 4'd4;
	localparam logic [3:0] ST_MW    = 4'd5;
	localparam logic [3:0] ST_MD    = 4'd6;
	localparam logic [3:0] ST_MF    = 4'd7;
	localparam logic [3:0] ST_SUM   = 4'd8;
	localparam logic [3:0] ST_CLAMP = 4'd9;
	localparam logic [3:0] ST_MP    = 4'd10;
	localparam logic [3:0] ST_MO    = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_nxt = ST_GOAL;
				end
			end
			ST_GOAL: begin
				cmd.goal = 1'b1;
				state_nxt = sts.need_div ? ST_DIV : ST_RAMP;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_QUO;
				end
			end
			ST_QUO: begin
				cmd.quo = 1'b1;
				state_nxt = ST_RAMP;
			end
			ST_RAMP: begin
				cmd.ramp = 1'b1;
				cmd.rom_en = 1'b1;
				cmd.rom_sel = OSC_WOW;
				state_nxt = ST_MW;
			end
			ST_MW: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SINE;
				cmd.gain_sel = OSC_WOW;
				cmd.rom_en = 1'b1;
				cmd.rom_sel = OSC_DRIFT;
				state_nxt = ST_MD;
			end
			ST_MD: begin
				cmd.acc_clr = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SINE;
				cmd.gain_sel = OSC_DRIFT;
				cmd.rom_en = 1'b1;
				cmd.rom_sel = OSC_FLUTTER;
				state_nxt = ST_MF;
			end
			ST_MF: begin
				cmd.acc_add = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SINE;
				cmd.gain_sel = OSC_FLUTTER;
				state_nxt = ST_SUM;
			end
			ST_SUM: begin
				cmd.acc_add = 1'b1;
				state_nxt = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_nxt = ST_MP;
			end
			ST_MP: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DEPTH;
				state_nxt = ST_MO;
			end
			ST_MO: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_OUT;
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_take_goes_to_goal: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_GOAL)
		else $error("accepted transaction did not start the target update");

	a_finish_only_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE && $past(state_q) == ST_OUT)
		else $error("output load outside the output state");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && sts.out_busy |=> state_q == ST_OUT)
		else $error("sequencer left the output state while stalled");

endmodule
`default_nettype wire

// ===== design/wfdm_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wfdm_dp
// Datapath: phase accumulators, amount ramp with bit-serial divider, sine
// table, shared multiplier, accumulator, clamp and output register.
// ----------------------------------------------------------------------------
module wfdm_dp import wfdm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [16:0] amount_target,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] offset
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam logic signed [ACC_W:0] T_ONE = (ACC_W + 1)'(1) << SUM_FRAC;
	localparam logic signed [ACC_W:0] T_TWO = (ACC_W + 1)'(1) << (SUM_FRAC + 1);

	logic [16:0] tgt_q;
	logic        restart_q;

	logic [31:0]        wow_angle_q;
	logic [31:0]        drift_angle_q;
	logic [31:0]        flutter_angle_q;
	logic [32:0]        now_q;
	logic [16:0]        goal_q;
	logic signed [33:0] step_q;
	logic [15:0]        steps_left_q;

	logic                 div_neg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [15:0]          rem_q;
	logic [32:0]          quo_q;

	logic [ROM_W-1:0]          rom_q;
	logic                      neg_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [U_W-1:0]            u22_q;
	logic [23:0]               p_q;

	logic        out_valid_q;
	logic [23:0] offset_q;

	logic [16:0]        tgt_sat;
	logic [32:0]        goal32;
	logic signed [33:0] diff;
	logic signed [33:0] diff_neg;
	logic [32:0]        diff_mag;
	logic signed [33:0] now_plus;
	logic signed [33:0] quo_pos;
	logic [16:0]        div_sh;
	logic [16:0]        div_trial;
	logic               div_ge;

	logic [31:0]                rom_angle;
	logic [SINE_TABLE_BITS-1:0] rom_idx;
	logic [ADDR_W-1:0]          rom_addr;

	logic signed [SINE_WIDTH-1:0] sine_pos;
	logic signed [SINE_WIDTH-1:0] sine_s;
	logic signed [15:0]           gain;
	logic [23:0]                  p_now;
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]    mul_b;

	logic signed [ACC_W:0] t_sum;
	logic signed [ACC_W:0] t_cl;
	logic [23:0]           result;

	assign tgt_sat  = (amount_target > AMOUNT_ONE) ? AMOUNT_ONE : amount_target;
	assign goal32   = {goal_q, 16'b0};
	assign diff     = signed'({1'b0, tgt_q, 16'b0}) - signed'({1'b0, now_q});
	assign diff_neg = -diff;
	assign diff_mag = diff[33] ? diff_neg[32:0] : diff[32:0];
	assign now_plus = signed'({1'b0, now_q}) + step_q;
	assign quo_pos  = signed'({1'b0, quo_q});

	assign div_sh    = {rem_q, quo_q[32]};
	assign div_trial = div_sh - {1'b0, cfg.ramp_steps};
	assign div_ge    = (div_sh >= {1'b0, cfg.ramp_steps});

	assign sts.need_div = (tgt_q != goal_q) && (cfg.ramp_steps != 16'd0);
	assign sts.div_last = (div_cnt_q == '0);
	assign sts.out_busy = out_valid_q && out_stall;

	always_comb begin
		unique case (cmd.rom_sel)
			OSC_WOW:     rom_angle = wow_angle_q;
			OSC_DRIFT:   rom_angle = drift_angle_q;
			OSC_FLUTTER: rom_angle = flutter_angle_q;
			default:     rom_angle = wow_angle_q;
		endcase
	end

	assign rom_idx  = rom_angle[29 -: SINE_TABLE_BITS];
	assign rom_addr = rom_angle[30] ? (ADDR_W'(TBL_N) - {1'b0, rom_idx}) : {1'b0, rom_idx};

	assign sine_pos = signed'({1'b0, rom_q});
	assign sine_s   = neg_q ? -sine_pos : sine_pos;
	assign p_now    = prod_q[45:22];

	always_comb begin
		unique case (cmd.gain_sel)
			OSC_WOW:     gain = cfg.wow_gain;
			OSC_DRIFT:   gain = cfg.drift_gain;
			OSC_FLUTTER: gain = cfg.flutter_gain;
			default:     gain = cfg.wow_gain;
		endcase
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_SINE: begin
				mul_a = MUL_A_W'(sine_s);
				mul_b = MUL_B_W'(gain);
			end
			MUL_DEPTH: begin
				mul_a = {1'b0, cfg.max_depth};
				mul_b = {10'b0, u22_q};
			end
			MUL_OUT: begin
				mul_a = {1'b0, p_now};
				mul_b = {1'b0, now_q[31:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign t_sum = {acc_q[ACC_W-1], acc_q} + T_ONE;
	assign t_cl  = t_sum[ACC_W] ? '0 : ((t_sum > T_TWO) ? T_TWO : t_sum);

	// amount of exactly one passes p through unscaled
	assign result = now_q[32] ? p_q : prod_q[55:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wow_angle_q     <= ANGLE_RESET;
			drift_angle_q   <= ANGLE_RESET;
			flutter_angle_q <= ANGLE_RESET;
			now_q           <= '0;
			goal_q          <= '0;
			step_q          <= '0;
			steps_left_q    <= '0;
		end else begin
			if (cmd.goal) begin
				if (restart_q) begin
					wow_angle_q     <= ANGLE_RESET;
					drift_angle_q   <= ANGLE_RESET;
					flutter_angle_q <= ANGLE_RESET;
				end
				if (tgt_q != goal_q) begin
					goal_q <= tgt_q;
					if (cfg.ramp_steps == 16'd0) begin
						now_q        <= {tgt_q, 16'b0};
						steps_left_q <= '0;
						step_q       <= '0;
					end else begin
						steps_left_q <= cfg.ramp_steps;
					end
				end
			end
			if (cmd.quo) begin
				step_q <= div_neg_q ? -quo_pos : quo_pos;
			end
			if (cmd.ramp) begin
				if (restart_q) begin
					now_q        <= goal32;
					steps_left_q <= '0;
					step_q       <= '0;
				end else if (steps_left_q == 16'd0) begin
					now_q <= goal32;
				end else begin
					steps_left_q <= steps_left_q - 16'd1;
					if (steps_left_q != 16'd1) begin
						now_q <= now_plus[32:0];
					end else begin
						now_q <= goal32;
					end
				end
			end
			if (cmd.finish) begin
				wow_angle_q     <= wow_angle_q + cfg.wow_step;
				drift_angle_q   <= drift_angle_q + cfg.drift_step;
				flutter_angle_q <= flutter_angle_q + cfg.flutter_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tgt_q     <= tgt_sat;
			restart_q <= restart;
		end
		if (cmd.goal) begin
			div_neg_q <= diff[33];
			quo_q     <= diff_mag;
			rem_q     <= '0;
			div_cnt_q <= DIV_CNT_W'(DIV_N - 1);
		end
		if (cmd.div_step) begin
			rem_q     <= div_ge ? div_trial[15:0] : div_sh[15:0];
			quo_q     <= {quo_q[31:0], div_ge};
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
		if (cmd.rom_en) begin
			rom_q <= SINE_ROM[rom_addr];
			neg_q <= rom_angle[31];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.mul_en && (cmd.mul_sel == MUL_OUT)) begin
			p_q <= p_now;
		end
		if (cmd.acc_clr) begin
			acc_q <= prod_q[ACC_W-1:0];
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q[ACC_W-1:0];
		end
		if (cmd.clamp) begin
			u22_q <= t_cl[SUM_FRAC+1:U_LSB];
		end
		if (cmd.finish) begin
			offset_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign offset    = offset_q;

	a_amount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		now_q <= {1'b1, 32'b0})
		else $error("amount above one");

	a_unipolar_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.clamp) |-> u22_q <= {1'b1, 22'b0})
		else $error("unipolar value above one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

// ===== tb/tb_wow_flutter_delay_modulator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wow_flutter_delay_modulator_core
// Self-checking bench for the wow/flutter delay modulator. A driver feeds
// samples from a queue, a local predictor of phases, amount ramp and scaling
// computes each offset, and a monitor compares every output transaction in
// order. Register settings change between phases; both sides stall at random.
// ----------------------------------------------------------------------------
module tb_wow_flutter_delay_modulator_core;
	import wfdm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint LUT_AMP = 32767;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

	typedef struct {
		logic [16:0] target;
		logic        restart;
	} sample_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [16:0]           amount_target = '0;
	logic                  restart = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [23:0]           offset;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sample_t     samples_pending[$];
	logic [23:0] offsets_due[$];
	int          mismatches = 0;
	int          send_idle = 32;
	int          recv_idle = 77;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;

	// predictor state and register mirror
	longint      sine_lut [0:TBL_N];
	bit [31:0]   osc_ph [3] = '{ANGLE_RESET, ANGLE_RESET, ANGLE_RESET};
	bit [31:0]   osc_step [3] = '{0, 0, 0};
	shortint     osc_gain [3] = '{0, 0, 0};
	bit [23:0]   depth_lim = '0;
	bit [15:0]   ramp_len = 16'd960;
	longint      amt_now = 0;
	bit [16:0]   amt_goal = '0;
	longint      amt_inc = 0;
	bit [15:0]   ramp_left = '0;

	wow_flutter_delay_modulator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.amount_target (amount_target),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.offset        (offset),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// quarter-wave sine, Taylor series in Q2.30, rounded half up
	function automatic void fill_sine_lut();
		bit [63:0] x;
		bit [63:0] x2;
		bit [63:0] term;
		longint    s;
		longint    v;
		for (int k = 0; k <= TBL_N; k++) begin
			x = (HALF_PI_Q30 * 64'(k)) / 64'(TBL_N);
			x2 = (x * x) >> 30;
			term = x;
			s = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				s = (n % 2 == 1) ? s - longint'(term) : s + longint'(term);
			end
			if (s < 0) s = 0;
			if (s > (longint'(1) <<< 30)) s = longint'(1) <<< 30;
			v = (s * LUT_AMP + (longint'(1) <<< 29)) >>> 30;
			sine_lut[k] = (v > LUT_AMP) ? LUT_AMP : v;
		end
	endfunction

	function automatic longint sine_at(bit [31:0] ang);
		bit [9:0] i;
		longint   v;
		i = ang[29:20];
		v = ang[30] ? sine_lut[TBL_N - i] : sine_lut[i];
		return ang[31] ? -v : v;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		case (idx)
			REG_WOW_STEP:     osc_step[0] = d;
			REG_DRIFT_STEP:   osc_step[1] = d;
			REG_FLUTTER_STEP: osc_step[2] = d;
			REG_WOW_GAIN:     osc_gain[0] = shortint'(d[15:0]);
			REG_DRIFT_GAIN:   osc_gain[1] = shortint'(d[15:0]);
			REG_FLUTTER_GAIN: osc_gain[2] = shortint'(d[15:0]);
			REG_MAX_DEPTH:    depth_lim = d[23:0];
			REG_RAMP_STEPS:   ramp_len = d[15:0];
			default: ;
		endcase
	endfunction

	function automatic logic [23:0] next_offset(logic [16:0] tgt_in, logic rst);
		bit [16:0] tgt;
		longint    goal_q32;
		longint    acc;
		longint    t;
		bit [63:0] u22;
		bit [63:0] p;
		bit [63:0] prod;
		tgt = (tgt_in > 17'd65536) ? 17'd65536 : tgt_in;
		if (tgt != amt_goal) begin
			amt_goal = tgt;
			if (ramp_len == 0) begin
				amt_now = longint'(tgt) <<< 16;
				ramp_left = 0;
				amt_inc = 0;
			end else begin
				ramp_left = ramp_len;
				amt_inc = ((longint'(tgt) <<< 16) - amt_now) / longint'(ramp_len);
			end
		end
		goal_q32 = longint'(amt_goal) <<< 16;
		if (rst) begin
			osc_ph = '{ANGLE_RESET, ANGLE_RESET, ANGLE_RESET};
			amt_now = goal_q32;
			ramp_left = 0;
			amt_inc = 0;
		end
		if (ramp_left == 0) begin
			amt_now = goal_q32;
		end else begin
			ramp_left--;
			amt_now = (ramp_left != 0) ? amt_now + amt_inc : goal_q32;
		end
		acc = 0;
		for (int i = 0; i < 3; i++) acc += sine_at(osc_ph[i]) * longint'(osc_gain[i]);
		t = acc + (longint'(1) <<< 30);
		if (t < 0) t = 0;
		if (t > (longint'(1) <<< 31)) t = longint'(1) <<< 31;
		u22 = t >> 9;
		p = (64'(depth_lim) * u22) >> 22;
		prod = (p * 64'(amt_now)) >> 32;
		for (int i = 0; i < 3; i++) osc_ph[i] += osc_step[i];
		return prod[23:0];
	endfunction

	always @(posedge clk) if (cfg_we) apply_reg(cfg_index, cfg_data);

	// driver
	always @(posedge clk) begin : drive_samples
		sample_t s;
		if (in_valid && !in_stall) offsets_due.push_back(next_offset(amount_target, restart));
		if (!in_valid || !in_stall) begin
			if (arst_n && samples_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
				s = samples_pending.pop_front();
				in_valid <= 1'b1;
				amount_target <= s.target;
				restart <= s.restart;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic report(string what, logic [23:0] want, logic [23:0] got);
		mismatches++;
		if (mismatches <= 10) $display("%0t %s: expected %h got %h", $time, what, want, got);
	endtask

	// monitor
	always @(posedge clk) begin : check_offsets
		logic [23:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (offsets_due.size() == 0) begin
				report("unexpected transaction", 'x, offset);
			end else begin
				want = offsets_due.pop_front();
				if (offset !== want) report("offset mismatch", want, offset);
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] ws, logic [31:0] ds, logic [31:0] fs,
			logic [15:0] wg, logic [15:0] dg, logic [15:0] fg,
			logic [23:0] md, logic [15:0] rs);
		write_reg(REG_WOW_STEP, ws);
		write_reg(REG_DRIFT_STEP, ds);
		write_reg(REG_FLUTTER_STEP, fs);
		write_reg(REG_WOW_GAIN, {16'h0, wg});
		write_reg(REG_DRIFT_GAIN, {16'h0, dg});
		write_reg(REG_FLUTTER_GAIN, {16'h0, fg});
		write_reg(REG_MAX_DEPTH, {8'h0, md});
		write_reg(REG_RAMP_STEPS, {16'h0, rs});
		@(negedge clk);
	endtask

	task automatic push(logic [16:0] tgt, logic rst);
		sample_t s;
		s.target = tgt;
		s.restart = rst;
		samples_pending.push_back(s);
	endtask

	task automatic settle();
		do @(negedge clk);
		while (samples_pending.size() != 0 || in_valid || offsets_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [31:0] st [3];
		logic [15:0] gn [3];
		logic [23:0] md;
		logic [15:0] rs;
		logic [16:0] last_tgt;
		int          r;

		fill_sine_lut();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ramps, saturation, restart
		write_all(32'h0100_0000, 32'h0010_0000, 32'h1000_0000,
			16'h7FFF, 16'h8000, 16'h4000, 24'hFF_FFFF, 16'd4);
		write_reg(REG_SPARE_LO, 32'h1234_5678);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		@(negedge clk);
		push(17'd65536, 1'b0);
		push(17'd65536, 1'b0);
		push(17'd65536, 1'b0);
		push(17'h1FFFF, 1'b0);
		push(17'd0, 1'b0);
		push(17'd0, 1'b0);
		push(17'd40000, 1'b1);
		push(17'd1, 1'b0);
		push(17'd1, 1'b1);
		push(17'h10001, 1'b0);
		push(17'd12345, 1'b0);
		settle();
		// zero ramp length
		write_reg(REG_RAMP_STEPS, 32'd0);
		@(negedge clk);
		push(17'd65536, 1'b0);
		push(17'd0, 1'b0);
		push(17'd32768, 1'b1);
		settle();
		// ramp length change mid-ramp
		write_reg(REG_RAMP_STEPS, 32'd960);
		@(negedge clk);
		push(17'd65536, 1'b0);
		push(17'd65536, 1'b0);
		settle();
		write_reg(REG_RAMP_STEPS, 32'd3);
		@(negedge clk);
		push(17'd65536, 1'b0);
		push(17'd100, 1'b0);
		push(17'd100, 1'b0);
		push(17'd100, 1'b0);
		settle();
		// sum clamps low, then high
		write_all(32'd0, 32'd0, 32'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'hFF_FFFF, 16'd0);
		push(17'd65536, 1'b1);
		push(17'd65536, 1'b0);
		settle();
		write_all(32'd0, 32'd0, 32'd0, 16'h8000, 16'h8000, 16'h8000, 24'hFF_FFFF, 16'd0);
		push(17'd65536, 1'b1);
		push(17'd65536, 1'b0);

		last_tgt = 17'd65536;
		for (int seg = 0; seg < 7; seg++) begin
			settle();
			if (seg < 3) begin
				send_idle = 32;
				recv_idle = 77;
			end else if (seg < 5) begin
				send_idle = 77;
				recv_idle = 32;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int i = 0; i < 3; i++) begin
				st[i] = $urandom_range(1) ? $urandom() : $urandom_range(32'h00FF_FFFF);
				gn[i] = 16'($urandom());
			end
			md = 24'($urandom());
			rs = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) :
				16'($urandom_range(24));
			if (seg == 1) begin
				st = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
				gn = '{16'h8000, 16'h8000, 16'h8000};
				md = 24'hFF_FFFF;
				rs = 16'hFFFF;
			end else if (seg == 2) begin
				gn = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
				md = 24'h00_0001;
				rs = 16'd0;
			end else if (seg == 4) begin
				st = '{32'd0, 32'd0, 32'd0};
				md = 24'd0;
			end
			write_all(st[0], st[1], st[2], gn[0], gn[1], gn[2], md, rs);
			for (int n = 0; n < 250; n++) begin
				r = $urandom_range(99);
				if (r < 55) begin
				end else if (r < 70) begin
					last_tgt = $urandom_range(1) ? 17'd65536 : 17'd0;
				end else if (r < 90) begin
					last_tgt = 17'($urandom_range(65536));
				end else begin
					last_tgt = 17'($urandom());
				end
				push(last_tgt, $urandom_range(19) == 0);
			end
			if (seg == 5) begin
				@(posedge clk);
				hold_req <= 1'b1;
			end
		end

		settle();
		if (mismatches == 0 && offsets_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/wfdm_pkg.sv
design/wfdm_ctrl.sv
design/wfdm_dp.sv
design/wow_flutter_delay_modulator_core.sv
tb/tb_wow_flutter_delay_modulator_core.sv
